[hdl/mcc_pkg.sv]
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types, character codes and Morse tables for the Morse codec.
// ----------------------------------------------------------------------------
package mcc_pkg;

  localparam int NUM_CODES     = 36;
  localparam int MAX_SYMBOLS   = 5;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [7:0] CHAR_DOT    = 8'h2e;
  localparam logic [7:0] CHAR_DASH   = 8'h2d;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_SLASH  = 8'h2f;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  localparam logic [5:0] FIRST_DIGIT = 6'd26;

  // One unit of work handed from front to back.
  typedef struct packed {
    logic       sep;          // leading space
    logic       glyph_valid;  // emit glyph instead of symbols
    logic [7:0] glyph;
    logic [2:0] sym_len;
    logic [4:0] sym_pat;      // bit i set: symbol i is a dash
  } job_t;

  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
  } code_t;

  typedef struct packed {
    logic       found;
    logic [7:0] glyph;
  } lookup_t;

  function automatic code_t morse_code(input logic [5:0] idx);
    code_t c;
    case (idx)
      6'd0:  c = '{3'd2, 5'd2};
      6'd1:  c = '{3'd4, 5'd1};
      6'd2:  c = '{3'd4, 5'd5};
      6'd3:  c = '{3'd3, 5'd1};
      6'd4:  c = '{3'd1, 5'd0};
      6'd5:  c = '{3'd4, 5'd4};
      6'd6:  c = '{3'd3, 5'd3};
      6'd7:  c = '{3'd4, 5'd0};
      6'd8:  c = '{3'd2, 5'd0};
      6'd9:  c = '{3'd4, 5'd14};
      6'd10: c = '{3'd3, 5'd5};
      6'd11: c = '{3'd4, 5'd2};
      6'd12: c = '{3'd2, 5'd3};
      6'd13: c = '{3'd2, 5'd1};
      6'd14: c = '{3'd3, 5'd7};
      6'd15: c = '{3'd4, 5'd6};
      6'd16: c = '{3'd4, 5'd11};
      6'd17: c = '{3'd3, 5'd2};
      6'd18: c = '{3'd3, 5'd0};
      6'd19: c = '{3'd1, 5'd1};
      6'd20: c = '{3'd3, 5'd4};
      6'd21: c = '{3'd4, 5'd8};
      6'd22: c = '{3'd3, 5'd6};
      6'd23: c = '{3'd4, 5'd9};
      6'd24: c = '{3'd4, 5'd13};
      6'd25: c = '{3'd4, 5'd3};
      6'd26: c = '{3'd5, 5'd31};
      6'd27: c = '{3'd5, 5'd30};
      6'd28: c = '{3'd5, 5'd28};
      6'd29: c = '{3'd5, 5'd24};
      6'd30: c = '{3'd5, 5'd16};
      6'd31: c = '{3'd5, 5'd0};
      6'd32: c = '{3'd5, 5'd1};
      6'd33: c = '{3'd5, 5'd3};
      6'd34: c = '{3'd5, 5'd7};
      6'd35: c = '{3'd5, 5'd15};
      default: c = '{3'd0, 5'd0};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] glyph_of(input logic [5:0] idx);
    logic [7:0] g;
    if (idx < FIRST_DIGIT) begin
      g = CHAR_UPPER_A + {2'b00, idx};
    end else begin
      g = CHAR_ZERO + {2'b00, idx - FIRST_DIGIT};
    end
    return g;
  endfunction

  // Compare the token against every table entry in parallel; first hit wins.
  function automatic lookup_t decode_token(input logic [2:0] len, input logic [4:0] pat);
    lookup_t r;
    code_t   c;
    r = '{1'b0, 8'h00};
    for (int k = NUM_CODES - 1; k >= 0; k--) begin
      c = morse_code(6'(k));
      if (c.len == len && c.pat == pat) begin
        r = '{1'b1, glyph_of(6'(k))};
      end
    end
    return r;
  endfunction

endpackage

[hdl/mcc_front.sv]
// ----------------------------------------------------------------------------
// mcc_front
// Accepts input words, tracks message and token state, builds jobs.
// ----------------------------------------------------------------------------
module mcc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    char_in,
  input  logic          message_end,
  input  logic          queue_full,
  output logic          push,
  output mcc_pkg::job_t job
);

  logic       direction;
  logic       emitted_any;
  logic [2:0] token_length;
  logic [4:0] token_pattern;
  logic       token_bad;
  logic       token_slash;

  logic       emitted_any_next;
  logic [2:0] token_length_next;
  logic [4:0] token_pattern_next;
  logic       token_bad_next;
  logic       token_slash_next;

  logic          accept;
  logic [7:0]    upper;
  logic [5:0]    idx;
  logic          enc_letter;
  logic          enc_digit;
  logic          enc_space;
  mcc_pkg::code_t   enc_code;
  logic          is_ws;
  logic [2:0]    t_len;
  logic [4:0]    t_pat;
  logic          t_bad;
  logic          t_slash;
  mcc_pkg::lookup_t hit;
  logic          emit;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  always_comb begin
    upper = char_in;
    if (char_in >= mcc_pkg::CHAR_LOWER_A && char_in <= mcc_pkg::CHAR_LOWER_Z) begin
      upper = char_in - mcc_pkg::CASE_OFFSET;
    end
    enc_letter = upper >= mcc_pkg::CHAR_UPPER_A && upper <= mcc_pkg::CHAR_UPPER_Z;
    enc_digit  = upper >= mcc_pkg::CHAR_ZERO && upper <= mcc_pkg::CHAR_NINE;
    enc_space  = upper == mcc_pkg::CHAR_SPACE;
    if (enc_letter) begin
      idx = 6'(upper - mcc_pkg::CHAR_UPPER_A);
    end else begin
      idx = 6'(upper - mcc_pkg::CHAR_ZERO) + mcc_pkg::FIRST_DIGIT;
    end
    enc_code = mcc_pkg::morse_code(idx);
  end

  // Absorb the byte into the pending token.
  always_comb begin
    is_ws   = char_in inside {mcc_pkg::CHAR_SPACE, [mcc_pkg::CHAR_TAB:mcc_pkg::CHAR_CR]};
    t_len   = token_length;
    t_pat   = token_pattern;
    t_bad   = token_bad;
    t_slash = token_slash;
    if (!is_ws) begin
      if (token_length >= 3'(mcc_pkg::MAX_SYMBOLS)) begin
        t_bad = 1'b1;
        t_len = 3'(mcc_pkg::MAX_SYMBOLS);
      end else begin
        case (char_in)
          mcc_pkg::CHAR_DOT: begin
            if (token_slash) t_bad = 1'b1;
          end
          mcc_pkg::CHAR_DASH: begin
            if (token_slash) t_bad = 1'b1;
            t_pat = token_pattern | (5'd1 << token_length);
          end
          mcc_pkg::CHAR_SLASH: begin
            if (token_length != 3'd0) t_bad = 1'b1;
            else t_slash = 1'b1;
          end
          default: t_bad = 1'b1;
        endcase
        t_len = token_length + 3'd1;
      end
    end
    hit = mcc_pkg::decode_token(t_len, t_pat);
  end

  always_comb begin
    emitted_any_next   = emitted_any;
    token_length_next  = token_length;
    token_pattern_next = token_pattern;
    token_bad_next     = token_bad;
    token_slash_next   = token_slash;
    emit               = 1'b0;
    job                = '0;
    if (!direction) begin
      job.sep         = emitted_any;
      job.glyph_valid = enc_space;
      job.glyph       = mcc_pkg::CHAR_SLASH;
      job.sym_len     = enc_code.len;
      job.sym_pat     = enc_code.pat;
      if (enc_letter || enc_digit || enc_space) begin
        emit             = 1'b1;
        emitted_any_next = 1'b1;
      end
    end else begin
      token_length_next  = t_len;
      token_pattern_next = t_pat;
      token_bad_next     = t_bad;
      token_slash_next   = t_slash;
      job.glyph_valid    = 1'b1;
      job.glyph          = t_slash ? mcc_pkg::CHAR_SPACE : hit.glyph;
      if (is_ws || message_end) begin
        emit               = (t_len != 3'd0) && !t_bad && (t_slash || hit.found);
        token_length_next  = 3'd0;
        token_pattern_next = 5'd0;
        token_bad_next     = 1'b0;
        token_slash_next   = 1'b0;
      end
    end
    if (message_end) emitted_any_next = 1'b0;
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= 1'b0;
      emitted_any   <= 1'b0;
      token_length  <= 3'd0;
      token_pattern <= 5'd0;
      token_bad     <= 1'b0;
      token_slash   <= 1'b0;
    end else if (cfg_we) begin
      // new direction starts a clean message
      direction     <= cfg_data;
      emitted_any   <= 1'b0;
      token_length  <= 3'd0;
      token_pattern <= 5'd0;
      token_bad     <= 1'b0;
      token_slash   <= 1'b0;
    end else if (accept) begin
      emitted_any   <= emitted_any_next;
      token_length  <= token_length_next;
      token_pattern <= token_pattern_next;
      token_bad     <= token_bad_next;
      token_slash   <= token_slash_next;
    end
  end

endmodule

[hdl/mcc_queue.sv]
// ----------------------------------------------------------------------------
// mcc_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
module mcc_queue #(
  parameter int DEPTH = mcc_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mcc_pkg::job_t push_job,
  input  logic          pop,
  output mcc_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcc_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = count == CNT_W'(0);
  assign full  = count == CNT_W'(DEPTH);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/mcc_back.sv]
// ----------------------------------------------------------------------------
// mcc_back
// Expands the head job into output words, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module mcc_back (
  input  logic          clk,
  input  logic          rst,
  input  mcc_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    char_out,
  output logic          last
);

  logic [2:0] pos;
  logic [2:0] total;
  logic [2:0] sym_idx;
  logic [4:0] sym_shift;
  logic       word_last;
  logic [7:0] word;
  logic       advance;

  always_comb begin
    total     = {2'b00, head.sep} + (head.glyph_valid ? 3'd1 : head.sym_len);
    sym_idx   = pos - {2'b00, head.sep};
    sym_shift = head.sym_pat >> sym_idx;
    word_last = pos == total - 3'd1;
    if (head.sep && pos == 3'd0) begin
      word = mcc_pkg::CHAR_SPACE;
    end else if (head.glyph_valid) begin
      word = head.glyph;
    end else begin
      word = sym_shift[0] ? mcc_pkg::CHAR_DASH : mcc_pkg::CHAR_DOT;
    end
  end

  assign advance = !empty && (!out_valid || !out_stall);
  assign pop     = advance && word_last;

  always_ff @(posedge clk) begin
    if (advance) begin
      char_out <= word;
      last     <= word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      pos       <= word_last ? 3'd0 : pos + 3'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= 3'd5)
    else $error("job position out of range");

  a_pos_has_job: assert property (@(posedge clk) disable iff (rst)
    pos != 3'd0 |-> !empty)
    else $error("job in progress but queue empty");

  a_glyph_single: assert property (@(posedge clk) disable iff (rst)
    advance && head.glyph_valid && !head.sep |=> out_valid && last)
    else $error("single glyph word not marked last");

  a_sep_first: assert property (@(posedge clk) disable iff (rst)
    advance && head.sep && pos == 3'd0 |=> char_out == mcc_pkg::CHAR_SPACE && !last)
    else $error("separator missing or marked last");

endmodule

[hdl/morse_code_codec.sv]
// ----------------------------------------------------------------------------
// morse_code_codec
// ASCII to Morse encoder and Morse to ASCII decoder, one byte per word.
// ----------------------------------------------------------------------------
// The front end takes one input byte per cycle whenever the job queue has
// room, updates the message and token state, and queues at most one job per
// byte. The back end turns each job into output words at one word per cycle
// while the output is not stalled, so an encoded character gives one to six
// words (a separator plus up to five symbols), a decoded token or a space one
// word, and a byte that yields nothing queues no job. The single output port
// of the back end sets the sustained rate. QUEUE_DEPTH jobs may wait between
// the two halves. Write direction only while the block is idle; the write
// also starts a new message.
module morse_code_codec #(
  parameter int QUEUE_DEPTH = mcc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       message_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       last
);

  mcc_pkg::job_t push_job;
  mcc_pkg::job_t head;
  logic          push;
  logic          pop;
  logic          empty;
  logic          full;

  mcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .message_end (message_end),
    .queue_full  (full),
    .push        (push),
    .job         (push_job)
  );

  mcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  mcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out),
    .last      (last)
  );

endmodule

[dv/tb_morse_code_codec.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_morse_code_codec
// Self-checking testbench for the Morse text encoder and decoder.
// ----------------------------------------------------------------------------
// A queue of pending bytes feeds a clocked driver; a clocked monitor predicts
// the output words of every accepted byte with a behavioral model of the
// codec and compares each accepted output word against the oldest prediction.
// Both directions run with directed and random text, random gaps on the input
// side and random stalls on the output side.
module tb_morse_code_codec;

  localparam int CLK_HALF   = 6;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE     = 24;

  typedef struct {
    logic [7:0] ch;
    logic       eom;
    bit         hold;   // wait for every pending word before sending
  } text_byte_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } morse_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       message_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;
  logic       last;

  text_byte_t  text_q[$];
  morse_word_t morse_exp_q[$];
  text_byte_t  nxt_byte;
  morse_word_t got_word;

  // codec model state
  bit         dir_decode;
  bit         enc_started;
  logic [2:0] tok_len;
  logic [4:0] tok_dash;
  bit         tok_bad;
  bit         tok_slash;

  bit in_taken = 1'b0;
  bit noisy = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int dir_writes = 0;
  int cycles = 0;

  morse_code_codec i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .message_end (message_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_out    (char_out),
    .last        (last)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic string morse_of(input int k);
    case (k)
      0:  return ".-";     1:  return "-...";   2:  return "-.-.";   3:  return "-..";
      4:  return ".";      5:  return "..-.";   6:  return "--.";    7:  return "....";
      8:  return "..";     9:  return ".---";   10: return "-.-";    11: return ".-..";
      12: return "--";     13: return "-.";     14: return "---";    15: return ".--.";
      16: return "--.-";   17: return ".-.";    18: return "...";    19: return "-";
      20: return "..-";    21: return "...-";   22: return ".--";    23: return "-..-";
      24: return "-.--";   25: return "--..";   26: return "-----";  27: return ".----";
      28: return "..---";  29: return "...--";  30: return "....-";  31: return ".....";
      32: return "-....";  33: return "--...";  34: return "---..";  35: return "----.";
      default: return "";
    endcase
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_token();
    tok_len = '0;
    tok_dash = '0;
    tok_bad = 1'b0;
    tok_slash = 1'b0;
  endtask

  task automatic predict_morse(input logic [7:0] c, input logic eom);
    logic [7:0] words[$];
    logic [7:0] u;
    logic [4:0] pat;
    string      s;
    int         idx;
    int         i;
    int         k;
    bit         ws;
    bit         found;
    if (!dir_decode) begin
      u = c;
      if (u >= mcc_pkg::CHAR_LOWER_A && u <= mcc_pkg::CHAR_LOWER_Z)
        u = u - mcc_pkg::CASE_OFFSET;
      idx = -1;
      if (u >= mcc_pkg::CHAR_UPPER_A && u <= mcc_pkg::CHAR_UPPER_Z)
        idx = int'(u - mcc_pkg::CHAR_UPPER_A);
      else if (u >= mcc_pkg::CHAR_ZERO && u <= mcc_pkg::CHAR_NINE)
        idx = 26 + int'(u - mcc_pkg::CHAR_ZERO);
      else if (u == mcc_pkg::CHAR_SPACE)
        idx = mcc_pkg::NUM_CODES;
      if (idx >= 0) begin
        if (enc_started) words.push_back(mcc_pkg::CHAR_SPACE);
        if (idx == mcc_pkg::NUM_CODES) begin
          words.push_back(mcc_pkg::CHAR_SLASH);
        end else begin
          s = morse_of(idx);
          for (i = 0; i < s.len(); i++) words.push_back(s[i]);
        end
        enc_started = 1'b1;
      end
    end else begin
      ws = (c == mcc_pkg::CHAR_SPACE) || (c >= mcc_pkg::CHAR_TAB && c <= mcc_pkg::CHAR_CR);
      if (!ws) begin
        if (tok_len >= 3'(mcc_pkg::MAX_SYMBOLS)) begin
          tok_bad = 1'b1;
          tok_len = 3'(mcc_pkg::MAX_SYMBOLS);
        end else begin
          if (c == mcc_pkg::CHAR_DOT || c == mcc_pkg::CHAR_DASH) begin
            if (tok_slash) tok_bad = 1'b1;
            if (c == mcc_pkg::CHAR_DASH) tok_dash[tok_len] = 1'b1;
          end else if (c == mcc_pkg::CHAR_SLASH) begin
            if (tok_len != 0) tok_bad = 1'b1;
            else tok_slash = 1'b1;
          end else begin
            tok_bad = 1'b1;
          end
          tok_len = tok_len + 3'd1;
        end
      end
      if (ws || eom) begin
        if (tok_len != 0 && !tok_bad) begin
          if (tok_slash) begin
            words.push_back(mcc_pkg::CHAR_SPACE);
          end else begin
            found = 1'b0;
            for (k = 0; k < mcc_pkg::NUM_CODES; k++) begin
              s = morse_of(k);
              pat = '0;
              for (i = 0; i < s.len(); i++)
                if (s[i] == mcc_pkg::CHAR_DASH) pat[i] = 1'b1;
              if (!found && s.len() == int'(tok_len) && pat == tok_dash) begin
                found = 1'b1;
                words.push_back(k < 26 ? 8'(mcc_pkg::CHAR_UPPER_A + k)
                                       : 8'(mcc_pkg::CHAR_ZERO + k - 26));
              end
            end
          end
        end
        clear_token();
      end
    end
    if (eom) enc_started = 1'b0;
    for (i = 0; i < words.size(); i++)
      morse_exp_q.push_back('{words[i], i == words.size() - 1});
  endtask

  task automatic push_byte(input logic [7:0] c, input logic eom, input bit hold);
    text_q.push_back('{c, eom, hold});
  endtask

  task automatic push_text(input string s, input bit eom_on_last);
    int i;
    for (i = 0; i < s.len(); i++) push_byte(s[i], eom_on_last && i == s.len() - 1, 1'b0);
  endtask

  task automatic set_direction(input bit d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    dir_decode = d;
    enc_started = 1'b0;
    clear_token();
    dir_writes++;
  endtask

  // Hold until every byte is sent and every word has come back, then settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (text_q.size() != 0 || in_valid || morse_exp_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic fill_random(input bit decode, input int n);
    logic [7:0] tok[$];
    logic [7:0] c;
    string      s;
    int         cnt;
    int         r;
    int         sc;
    int         i;
    bit         held;
    bit         hold_now;
    bit         eom_tok;
    cnt = 0;
    held = 1'b0;
    while (cnt < n) begin
      hold_now = !held && cnt >= n / 2;
      if (hold_now) held = 1'b1;
      r = $urandom_range(0, 99);
      if (!decode) begin
        if (r < 55) c = 8'(mcc_pkg::CHAR_UPPER_A + $urandom_range(0, 25)) |
                        ($urandom_range(0, 1) ? mcc_pkg::CASE_OFFSET : 8'h00);
        else if (r < 70) c = 8'(mcc_pkg::CHAR_ZERO + $urandom_range(0, 9));
        else if (r < 82) c = mcc_pkg::CHAR_SPACE;
        else c = 8'($urandom_range(0, 255));
        push_byte(c, $urandom_range(0, 11) == 0, hold_now);
        cnt++;
      end else begin
        tok = {};
        if (r < 65 || r >= 83 && r < 93) begin
          s = morse_of($urandom_range(0, mcc_pkg::NUM_CODES - 1));
          for (i = 0; i < s.len(); i++) tok.push_back(s[i]);
          // corrupt the token with a random byte
          if (r >= 83) tok.insert($urandom_range(0, tok.size()), 8'($urandom_range(0, 255)));
        end else if (r < 75) begin
          tok.push_back(mcc_pkg::CHAR_SLASH);
          if ($urandom_range(0, 4) == 0) tok.push_back(mcc_pkg::CHAR_DOT);
        end else if (r < 83) begin
          repeat ($urandom_range(6, 8))
            tok.push_back($urandom_range(0, 1) ? mcc_pkg::CHAR_DASH : mcc_pkg::CHAR_DOT);
        end else begin
          tok.push_back(8'($urandom_range(0, 255)));
        end
        sc = $urandom_range(0, 9);
        eom_tok = (sc == 8);
        for (i = 0; i < tok.size(); i++)
          push_byte(tok[i], eom_tok && i == tok.size() - 1, hold_now && i == 0);
        cnt += tok.size();
        if (sc <= 5) push_byte(mcc_pkg::CHAR_SPACE, 1'b0, 1'b0);
        else if (sc == 6)
          push_byte(8'($urandom_range(mcc_pkg::CHAR_TAB, mcc_pkg::CHAR_CR)), 1'b0, 1'b0);
        else if (sc == 7) begin
          push_byte(mcc_pkg::CHAR_SPACE, 1'b0, 1'b0);
          push_byte(mcc_pkg::CHAR_SPACE, 1'b0, 1'b0);
          cnt++;
        end else if (sc == 9) push_byte(mcc_pkg::CHAR_SPACE, 1'b1, 1'b0);
        if (sc != 8) cnt++;
      end
    end
  endtask

  // Input driver: advance to the next byte once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (text_q.size() != 0 && !(text_q[0].hold && morse_exp_q.size() != 0)) begin
        nxt_byte = text_q.pop_front();
        in_valid <= 1'b1;
        char_in <= nxt_byte.ch;
        message_end <= nxt_byte.eom;
        gap_left = noisy ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = noisy ? pick_gap() : 0;
    end
  end

  // Monitor: predict on input handshakes, check on output handshakes.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        predict_morse(char_in, message_end);
        bytes_sent++;
      end
      if (out_valid && !out_stall) begin
        if (morse_exp_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual char_out=%h last=%b",
                   $time, char_out, last);
          errors++;
        end else begin
          got_word = morse_exp_q.pop_front();
          if (char_out !== got_word.ch) begin
            $display("%0t: char_out mismatch: expected %h, actual %h",
                     $time, got_word.ch, char_out);
            errors++;
          end
          if (last !== got_word.last) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time, got_word.last, last);
            errors++;
          end
          words_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d words still expected", $time, morse_exp_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    dir_decode = 1'b0;
    enc_started = 1'b0;
    clear_token();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed encode: case folding, digit, space, skipped bytes, message end
    noisy = 1'b1;
    set_direction(1'b0);
    push_text("z9 !", 1'b0);
    push_byte(8'hff, 1'b1, 1'b0);
    push_byte("Q", 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    wait_idle();

    // directed decode: foreign byte, slash, too long, slash after symbols,
    // other whitespace, flush on message end
    set_direction(1'b1);
    push_text("-x\t/ ......\013.-/\015-----", 1'b1);
    wait_idle();

    set_direction(1'b0);
    fill_random(1'b0, 40);
    wait_idle();

    set_direction(1'b1);
    fill_random(1'b1, 40);
    wait_idle();

    // steady traffic, no gaps or stalls
    noisy = 1'b0;
    set_direction(1'b1);
    fill_random(1'b1, 12);
    wait_idle();

    set_direction(1'b0);
    fill_random(1'b0, 12);
    wait_idle();

    if (morse_exp_q.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, morse_exp_q.size());
      errors++;
    end
    $display("Sent %0d bytes and checked %0d words over %0d direction writes,",
             bytes_sent, words_checked, dir_writes);
    $display("encoding and decoding with and without gaps and back-pressure.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/mcc_pkg.sv
hdl/mcc_front.sv
hdl/mcc_queue.sv
hdl/mcc_back.sv
hdl/morse_code_codec.sv
dv/tb_morse_code_codec.sv
